>>> design/multi_channel_fade_envelope_unit_assert.svh
// Assertion macros shared by the fade envelope RTL.
// Each macro expects clk and rst_n to be visible in the including module.
`ifndef MULTI_CHANNEL_FADE_ENVELOPE_UNIT_ASSERT_SVH
`define MULTI_CHANNEL_FADE_ENVELOPE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MCFE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MCFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mcfe_pkg.sv
// Shared types and constants for the multi-channel fade envelope unit.
// No dependencies; used by mcfe_div and the top level.
package mcfe_pkg;

  localparam int TIME_W  = 32;
  localparam int MS_W    = 16;
  localparam int CHIN_W  = 4;
  localparam int LEVEL_W = 16;
  localparam int CNT_W   = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int DIV_STEPS  = 16;
  localparam int STEP_W     = 4;

  // Unity level in unsigned Q1.15.
  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 16'h8000;

  // Request codes.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODEL_PRESENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'b1;

  // Divider request: dividend must not exceed divisor, divisor is nonzero.
  typedef struct packed {
    logic             start;
    logic [MS_W-1:0]  dividend;
    logic [MS_W-1:0]  divisor;
  } div_req_t;

  // Divider response: done pulses for one cycle with the quotient.
  typedef struct packed {
    logic              done;
    logic [LEVEL_W-1:0] quot;
  } div_rsp_t;

endpackage

>>> design/mcfe_div.sv
// Serial restoring divider giving floor(dividend * 32768 / divisor).
// Depends on mcfe_pkg for the request and response types.
module mcfe_div (
  input  logic               clk,
  input  logic               rst_n,
  input  mcfe_pkg::div_req_t req,
  output mcfe_pkg::div_rsp_t rsp
);
  import mcfe_pkg::*;

  logic [MS_W:0]      rem_r, rem_nxt;
  logic [LEVEL_W-1:0] quo_r, quo_nxt;
  logic [MS_W-1:0]    dvs_r;
  logic [STEP_W-1:0]  step_r;
  logic               busy_r;
  logic               done_r;
  logic [MS_W:0]      trial;
  logic               fits;

  // First step compares the dividend itself, later steps shift the remainder.
  always_comb begin
    trial   = (step_r == '0) ? rem_r : {rem_r[MS_W-1:0], 1'b0};
    fits    = (trial >= {1'b0, dvs_r});
    rem_nxt = fits ? (trial - {1'b0, dvs_r}) : trial;
    quo_nxt = {quo_r[LEVEL_W-2:0], fits};
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= {1'b0, req.dividend};
      dvs_r <= req.divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

>>> design/multi_channel_fade_envelope_unit.sv
// Multi-channel fade envelope unit. A start request gives no result.
// A tick walks the channels, each through read, evaluate, compare and output; a
// fading channel also waits on the 16-step serial divider, and the output can stall.
// Input is stalled from a tick's transfer until its last result is transferred.
// Synchronous active-low reset clears all channels to off with level zero.
// Depends on mcfe_pkg, mcfe_div and the assertion macro header.
`include "multi_channel_fade_envelope_unit_assert.svh"

module multi_channel_fade_envelope_unit #(
  parameter int MAX_CHANNELS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_req_type,
  input  logic [mcfe_pkg::CHIN_W-1:0]       in_channel_index,
  input  logic [mcfe_pkg::MS_W-1:0]         in_rise_ms,
  input  logic [mcfe_pkg::MS_W-1:0]         in_fall_ms,
  input  logic [mcfe_pkg::TIME_W-1:0]       in_time_now,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mcfe_pkg::CHIN_W-1:0]       out_channel_index_out,
  output logic [mcfe_pkg::LEVEL_W-1:0]      out_level,
  output logic                              out_active,
  output logic                              out_last,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mcfe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mcfe_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mcfe_pkg::*;

  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int LIM_W = $clog2(MAX_CHANNELS + 1);
  localparam int TIM_W = TIME_W + 2 * MS_W;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_EVAL, S_CMP, S_DIV, S_OUT
  } state_t;

  state_t             state_r, state_nxt;
  logic               model_present_r;
  logic [CNT_W-1:0]   channel_count_r;

  logic [CH_W-1:0]    n_r, n_nxt;
  logic [LIM_W-1:0]   lim_r, lim_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [TIME_W-1:0]  elapsed_r, elapsed_nxt;
  logic [MS_W:0]      span_r, span_nxt;
  logic               falling_r, falling_nxt;

  logic [MAX_CHANNELS-1:0] act_r, act_nxt;
  logic [MAX_CHANNELS-1:0] started_r, started_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [CHIN_W-1:0]  out_ch_r, out_ch_nxt;
  logic [LEVEL_W-1:0] out_level_r, out_level_nxt;
  logic               out_active_r, out_active_nxt;
  logic               out_last_r, out_last_nxt;

  // Channel timing and level memories.
  logic [TIM_W-1:0]   tim_mem [MAX_CHANNELS];
  logic [LEVEL_W-1:0] lvl_mem [MAX_CHANNELS];
  logic [TIM_W-1:0]   tim_rd_r;
  logic [LEVEL_W-1:0] lvl_rd_r;
  logic               tim_we;
  logic [CH_W-1:0]    tim_wa;
  logic [TIM_W-1:0]   tim_wd;
  logic               lvl_we;
  logic [CH_W-1:0]    lvl_wa;
  logic [LEVEL_W-1:0] lvl_wd;

  logic               in_xfer;
  logic               out_xfer;
  logic               is_last;
  logic [TIME_W-1:0]  st_time;
  logic [MS_W-1:0]    st_rise;
  logic [MS_W-1:0]    st_fall;
  logic [LEVEL_W-1:0] cur_level;
  logic [MS_W-1:0]    rise_min;
  logic [MS_W-1:0]    fall_min;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign cfg_ready = 1'b1;

  assign {st_time, st_rise, st_fall} = tim_rd_r;
  assign cur_level = started_r[n_r] ? lvl_rd_r : '0;
  assign is_last   = ((LIM_W+1)'(n_r) + 1'b1) == (LIM_W+1)'(lim_r);
  assign rise_min  = (in_rise_ms == '0) ? MS_W'(1) : in_rise_ms;
  assign fall_min  = (in_fall_ms == '0) ? MS_W'(1) : in_fall_ms;

  mcfe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      model_present_r <= 1'b0;
      channel_count_r <= CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODEL_PRESENT: model_present_r <= cfg_data[0];
        CFG_CHANNEL_COUNT: channel_count_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: accepts a request; a start writes one channel, a tick walks channels one at a time.
  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    lim_nxt        = lim_r;
    now_nxt        = now_r;
    elapsed_nxt    = elapsed_r;
    span_nxt       = span_r;
    falling_nxt    = falling_r;
    act_nxt        = act_r;
    started_nxt    = started_r;
    out_valid_nxt  = out_valid_r;
    out_ch_nxt     = out_ch_r;
    out_level_nxt  = out_level_r;
    out_active_nxt = out_active_r;
    out_last_nxt   = out_last_r;
    tim_we         = 1'b0;
    tim_wa         = CH_W'(in_channel_index);
    tim_wd         = {in_time_now, rise_min, fall_min};
    lvl_we         = 1'b0;
    lvl_wa         = CH_W'(in_channel_index);
    lvl_wd         = '0;
    div_req.start    = 1'b0;
    div_req.dividend = elapsed_r[MS_W-1:0];
    div_req.divisor  = st_rise;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && model_present_r) begin
          if (in_req_type == REQ_START) begin
            if (int'(in_channel_index) < MAX_CHANNELS) begin
              tim_we = 1'b1;
              lvl_we = 1'b1;
              act_nxt[CH_W'(in_channel_index)]     = 1'b1;
              started_nxt[CH_W'(in_channel_index)] = 1'b1;
            end
          end else begin
            now_nxt = in_time_now;
            n_nxt   = '0;
            if (int'(channel_count_r) > MAX_CHANNELS) begin
              lim_nxt = LIM_W'(MAX_CHANNELS);
            end else begin
              lim_nxt = LIM_W'(channel_count_r);
            end
            if (channel_count_r != '0) begin
              state_nxt = S_RD;
            end
          end
        end
      end
      S_RD: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        elapsed_nxt = now_r - st_time;
        span_nxt    = {1'b0, st_rise} + {1'b0, st_fall};
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        out_ch_nxt   = CHIN_W'(n_r);
        out_last_nxt = is_last;
        if (!act_r[n_r] || (elapsed_r > TIME_W'(span_r))) begin
          // Idle channel, or fade just ended: report the stored level.
          act_nxt[n_r]   = 1'b0;
          out_level_nxt  = cur_level;
          out_active_nxt = 1'b0;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_OUT;
        end else begin
          div_req.start = 1'b1;
          if (elapsed_r < TIME_W'(st_rise)) begin
            falling_nxt = 1'b0;
          end else begin
            falling_nxt      = 1'b1;
            div_req.dividend = MS_W'(elapsed_r[MS_W:0] - {1'b0, st_rise});
            div_req.divisor  = st_fall;
          end
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          lvl_wd         = falling_r ? (LEVEL_ONE - div_rsp.quot) : div_rsp.quot;
          lvl_we         = 1'b1;
          lvl_wa         = n_r;
          out_level_nxt  = lvl_wd;
          out_active_nxt = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_OUT;
        end
      end
      S_OUT: begin
        if (out_xfer) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            n_nxt     = n_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      act_r       <= '0;
      started_r   <= '0;
      out_valid_r <= 1'b0;
      n_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      act_r       <= act_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
    end
    lim_r        <= lim_nxt;
    now_r        <= now_nxt;
    elapsed_r    <= elapsed_nxt;
    span_r       <= span_nxt;
    falling_r    <= falling_nxt;
    out_ch_r     <= out_ch_nxt;
    out_level_r  <= out_level_nxt;
    out_active_r <= out_active_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Memory ports: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (tim_we) begin
      tim_mem[tim_wa] <= tim_wd;
    end
    tim_rd_r <= tim_mem[n_r];
  end

  always_ff @(posedge clk) begin
    if (lvl_we) begin
      lvl_mem[lvl_wa] <= lvl_wd;
    end
    lvl_rd_r <= lvl_mem[n_r];
  end

  assign out_valid             = out_valid_r;
  assign out_channel_index_out = out_ch_r;
  assign out_level             = out_level_r;
  assign out_active            = out_active_r;
  assign out_last              = out_last_r;

  // A result is only presented from the output state.
  `MCFE_ASSERT_IMP(a_out_in_state, out_valid_r, state_r == S_OUT, "result outside output state")
  // Levels never exceed unity.
  `MCFE_ASSERT_IMP(a_level_range, out_valid_r, out_level_r <= LEVEL_ONE, "level above 1.0")
  // The final result of a tick returns the sequencer to idle.
  `MCFE_ASSERT_NEXT(a_last_idle, out_xfer && out_last_r, state_r == S_IDLE, "no idle after last")
  // A divider result only arrives while the sequencer waits for it.
  `MCFE_ASSERT_IMP(a_div_wait, div_rsp.done, state_r == S_DIV, "divider done while not waiting")

endmodule

>>> sim/multi_channel_fade_envelope_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the multi-channel fade envelope unit.
// Needs mcfe_pkg and the multi_channel_fade_envelope_unit RTL; an in-bench envelope
// predictor checks every level transfer against a queue of expected results.
module multi_channel_fade_envelope_unit_test;
  import mcfe_pkg::*;

  localparam int N_CHAN = 16;
  localparam int SETTLE_CYCLES = 100;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 400;

  // One request as driven on the input channel, with an optional typed-in result.
  typedef struct packed {
    logic                req;
    logic [CHIN_W-1:0]   ch;
    logic [MS_W-1:0]     rise;
    logic [MS_W-1:0]     fall;
    logic [TIME_W-1:0]   now;
    logic                typed;
    logic [LEVEL_W-1:0]  level;
    logic                active;
  } stim_row_t;

  // One level report as seen on the result channel.
  typedef struct packed {
    logic [CHIN_W-1:0]   ch;
    logic [LEVEL_W-1:0]  level;
    logic                active;
    logic                is_last;
  } level_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_req_type = REQ_START;
  logic [CHIN_W-1:0]    in_channel_index = '0;
  logic [MS_W-1:0]      in_rise_ms = '0;
  logic [MS_W-1:0]      in_fall_ms = '0;
  logic [TIME_W-1:0]    in_time_now = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b1;
  logic [CHIN_W-1:0]    out_channel_index_out;
  logic [LEVEL_W-1:0]   out_level;
  logic                 out_active;
  logic                 out_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MODEL_PRESENT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state: configuration and per-channel envelopes.
  logic                 model_on = 1'b0;
  logic [CNT_W-1:0]     walk_count = 5'd1;
  logic                 fading [N_CHAN];
  logic [TIME_W-1:0]    start_ms [N_CHAN];
  logic [MS_W-1:0]      rise_len [N_CHAN];
  logic [MS_W-1:0]      fall_len [N_CHAN];
  logic [LEVEL_W-1:0]   level_now [N_CHAN];
  level_result_t        expected_levels [$];

  logic [TIME_W-1:0]    clock_ms = 32'd0;
  int                   tx_idle_pct = 8;
  int                   rx_idle_pct = 77;
  bit                   pressure_armed = 1'b0;
  int                   mismatches = 0;

  // Directed requests; typed results hold for a walk of channel 0 only.
  stim_row_t directed_rows [0:21] = '{
    '{REQ_TICK,  4'd0,  16'd0,      16'd0,      32'd0,         1'b1, 16'd0,     1'b0},
    '{REQ_START, 4'd0,  16'd0,      16'd0,      32'd100,       1'b0, 16'd0,     1'b0},
    '{REQ_TICK,  4'd0,  16'd0,      16'd0,      32'd100,       1'b1, 16'd0,     1'b1},
    '{REQ_TICK,  4'd0,  16'd0,      16'd0,      32'd101,       1'b1, LEVEL_ONE, 1'b1},
    '{REQ_TICK,  4'd0,  16'd0,      16'd0,      32'd102,       1'b1, 16'd0,     1'b1},
    '{REQ_TICK,  4'd0,  16'd0,      16'd0,      32'd103,       1'b1, 16'd0,     1'b0},
    '{REQ_START, 4'd0,  16'hFFFF,   16'hFFFF,   32'hFFFF_0000, 1'b0, 16'd0,     1'b0},
    '{REQ_TICK,  4'd0,  16'd0,      16'd0,      32'hFFFF_7FFF, 1'b0, 16'd0,     1'b0},
    '{REQ_TICK,  4'd0,  16'd0,      16'd0,      32'hFFFF_FFFF, 1'b1, LEVEL_ONE, 1'b1},
    '{REQ_TICK,  4'd0,  16'd0,      16'd0,      32'h0000_FFFE, 1'b1, 16'd0,     1'b1},
    '{REQ_TICK,  4'd0,  16'd0,      16'd0,      32'h0000_FFFF, 1'b1, 16'd0,     1'b0},
    '{REQ_START, 4'd0,  16'd1000,   16'd3,      32'd5000,      1'b0, 16'd0,     1'b0},
    '{REQ_TICK,  4'd0,  16'd0,      16'd0,      32'd4999,      1'b1, 16'd0,     1'b0},
    '{REQ_START, 4'd15, 16'hAAAA,   16'h5555,   32'h5555_AAAA, 1'b0, 16'd0,     1'b0},
    '{REQ_START, 4'd0,  16'd4,      16'd8,      32'd200,       1'b0, 16'd0,     1'b0},
    '{REQ_TICK,  4'd0,  16'd0,      16'd0,      32'd202,       1'b1, 16'd16384, 1'b1},
    '{REQ_TICK,  4'd0,  16'd0,      16'd0,      32'd206,       1'b1, 16'd24576, 1'b1},
    '{REQ_TICK,  4'd0,  16'd0,      16'd0,      32'd207,       1'b0, 16'd0,     1'b0},
    '{REQ_TICK,  4'd0,  16'd0,      16'd0,      32'd212,       1'b0, 16'd0,     1'b0},
    '{REQ_START, 4'd0,  16'd3,      16'd7,      32'd300,       1'b0, 16'd0,     1'b0},
    '{REQ_TICK,  4'd0,  16'd0,      16'd0,      32'd301,       1'b0, 16'd0,     1'b0},
    '{REQ_TICK,  4'd0,  16'd0,      16'd0,      32'd305,       1'b0, 16'd0,     1'b0}
  };

  multi_channel_fade_envelope_unit #(
    .MAX_CHANNELS(N_CHAN)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_channel_index(in_channel_index),
    .in_rise_ms(in_rise_ms),
    .in_fall_ms(in_fall_ms),
    .in_time_now(in_time_now),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_channel_index_out(out_channel_index_out),
    .out_level(out_level),
    .out_active(out_active),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Apply one accepted request to the envelope bank and queue the levels a tick reports.
  function automatic void advance_envelopes(input stim_row_t item);
    int            n;
    int            walk;
    logic [31:0]   elapsed;
    logic [63:0]   scaled;
    if (!model_on) return;
    if (item.req == REQ_START) begin
      fading[item.ch] = 1'b1;
      start_ms[item.ch] = item.now;
      rise_len[item.ch] = (item.rise == 0) ? 16'd1 : item.rise;
      fall_len[item.ch] = (item.fall == 0) ? 16'd1 : item.fall;
      level_now[item.ch] = '0;
      return;
    end
    walk = (walk_count > N_CHAN) ? N_CHAN : int'(walk_count);
    for (n = 0; n < walk; n++) begin
      if (fading[n]) begin
        elapsed = item.now - start_ms[n];
        if (33'(elapsed) > 33'(rise_len[n]) + 33'(fall_len[n])) begin
          fading[n] = 1'b0;
        end else if (elapsed < 32'(rise_len[n])) begin
          scaled = (64'(elapsed) * 64'(LEVEL_ONE)) / 64'(rise_len[n]);
          level_now[n] = scaled[15:0];
        end else begin
          // Past the peak: count down from unity over the fall time.
          scaled = (64'(elapsed - 32'(rise_len[n])) * 64'(LEVEL_ONE)) / 64'(fall_len[n]);
          level_now[n] = 16'(32'(LEVEL_ONE) - scaled[31:0]);
        end
      end
      expected_levels.push_back('{4'(n), level_now[n], fading[n], (n == walk - 1)});
    end
  endfunction

  // Fade times: mostly short so ticks land inside the ramps, sometimes zero or full range.
  function automatic logic [MS_W-1:0] pick_duration();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return 16'($urandom());
    return 16'($urandom_range(40, 1));
  endfunction

  // Offer one request and hold it until the transfer, then update the predictor.
  task automatic send_req(input stim_row_t item);
    int idx;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= item.req;
    in_channel_index <= item.ch;
    in_rise_ms <= item.rise;
    in_fall_ms <= item.fall;
    in_time_now <= item.now;
    do @(posedge clk); while (in_stall);
    advance_envelopes(item);
    if (item.typed) begin
      idx = expected_levels.size() - 1;
      expected_levels[idx] = '{4'd0, item.level, item.active, 1'b1};
    end
  endtask

  // Stop offering, wait for every expected level, then let the block go idle.
  task automatic quiesce();
    @(negedge clk) in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers while the block is idle.
  task automatic set_config(input logic present, input logic [CNT_W-1:0] count);
    int i;
    quiesce();
    for (i = 0; i < 2; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      if (i == 0) begin
        cfg_index <= CFG_MODEL_PRESENT;
        cfg_data <= {4'($urandom()), present};
      end else begin
        cfg_index <= CFG_CHANNEL_COUNT;
        cfg_data <= count;
      end
      do @(posedge clk); while (!cfg_ready);
      if (i == 0) model_on = present;
      else walk_count = count;
    end
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // Random traffic: starts mostly on walked channels, ticks moving time forward, plus time jumps.
  task automatic run_random(input int n_items);
    stim_row_t item;
    int        k;
    int        pick;
    int        hi;
    for (k = 0; k < n_items; k++) begin
      pick = $urandom_range(99);
      hi = (walk_count == 0 || walk_count > N_CHAN) ? N_CHAN - 1 : int'(walk_count) - 1;
      if (pick >= 90) begin
        if ($urandom_range(1)) clock_ms = $urandom();
        else clock_ms = clock_ms - $urandom_range(50, 1);
      end else if (pick >= 35) begin
        clock_ms = clock_ms + $urandom_range(12);
      end
      item = '0;
      item.req = (pick < 35) ? REQ_START : (pick < 90) ? REQ_TICK : 1'($urandom_range(1));
      item.ch = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(hi));
      item.rise = pick_duration();
      item.fall = pick_duration();
      item.now = clock_ms;
      send_req(item);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off when pressure is armed.
  bit pressure_taken = 1'b0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (pressure_armed && !pressure_taken) begin
      hold_left = HOLD_OFF_CYCLES;
      pressure_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Compare each level transfer with the oldest expectation.
  always @(posedge clk) begin
    level_result_t got;
    level_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_channel_index_out, out_level, out_active, out_last};
      if (expected_levels.size() == 0) begin
        $display("%0t: unexpected result ch %0d level %0d active %0d last %0d", $time,
                 got.ch, got.level, got.active, got.is_last);
        mismatches = mismatches + 1;
      end else begin
        want = expected_levels.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected ch %0d level %0d active %0d last %0d, got ch %0d level %0d active %0d last %0d",
                   $time, want.ch, want.level, want.active, want.is_last,
                   got.ch, got.level, got.active, got.is_last);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer of any kind happens for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int i;
    for (i = 0; i < N_CHAN; i++) begin
      fading[i] = 1'b0;
      level_now[i] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Sender idles lightly, receiver heavily. Nothing is attached yet, so all is ignored.
    tx_idle_pct = 8;
    rx_idle_pct = 77;
    run_random(4);
    set_config(1'b1, 5'd1);
    for (i = 0; i < 22; i++) send_req(directed_rows[i]);
    set_config(1'b1, 5'd16);
    clock_ms = 32'h5555_C000;
    run_random(50);

    // Roles swapped: count above the bank size, then a count of zero.
    tx_idle_pct = 77;
    rx_idle_pct = 8;
    set_config(1'b1, 5'd31);
    run_random(35);
    set_config(1'b1, 5'd0);
    run_random(10);

    // No idling on either side; detach briefly, then fill the block under a long hold-off.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_config(1'b1, 5'd5);
    run_random(30);
    set_config(1'b0, 5'd5);
    run_random(5);
    set_config(1'b1, 5'd16);
    pressure_armed = 1'b1;
    run_random(30);

    quiesce();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/mcfe_pkg.sv
design/mcfe_div.sv
design/multi_channel_fade_envelope_unit.sv
sim/multi_channel_fade_envelope_unit_test.sv
